/* rtl/ctbk_pkg.sv */
// Shared types, codes and constants of the cascadable timer bank.
package ctbk_pkg;

    localparam int NUM_TIMERS_DEFAULT  = 4;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int PRESCALE_WIDTH = 10;
    localparam int NUM_PRESCALE   = 4;
    localparam int IRQ_WIDTH      = 4;
    localparam int DATA_WIDTH     = 16;
    localparam int CTL_WIDTH      = 8;

    // Control byte bit positions.
    localparam int CTL_COUNT_UP_BIT = 2;
    localparam int CTL_IRQ_BIT      = 6;
    localparam int CTL_ENABLE_BIT   = 7;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic {
        REG_COUNT   = 1'b0,
        REG_CONTROL = 1'b1
    } reg_sel_t;

    // One tick of time as seen by every cell.
    typedef struct packed {
        logic                    tick;
        logic [NUM_PRESCALE-1:0] strobe;
    } ctbk_tick_t;

    // A register write as seen by one cell.
    typedef struct packed {
        logic                  wr_en;
        logic                  reg_sel;
        logic [1:0]            byte_enable;
        logic [DATA_WIDTH-1:0] write_data;
    } ctbk_bus_t;

    // Mask of the prescale time bits that must be zero for a count.
    function automatic logic [PRESCALE_WIDTH-1:0] prescale_mask(input logic [1:0] sel);
        logic [PRESCALE_WIDTH-1:0] mask;
        case (sel)
            2'd0:    mask = 10'h000;
            2'd1:    mask = 10'h03F;
            2'd2:    mask = 10'h0FF;
            default: mask = 10'h3FF;
        endcase
        return mask;
    endfunction

endpackage

/* rtl/ctbk_prescaler.sv */
// Prescale time, advanced on each tick, and the four divider strobes it produces.
module ctbk_prescaler
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_en,
    output ctbk_pkg::ctbk_tick_t  tick_info
);

    logic [ctbk_pkg::PRESCALE_WIDTH-1:0] time_reg;
    logic [ctbk_pkg::PRESCALE_WIDTH-1:0] time_next;

    // The strobes look at the time after this tick's increment.
    assign time_next = time_reg + ctbk_pkg::PRESCALE_WIDTH'(1);

    always_comb
    begin
        tick_info.tick = tick_en;
        for (int k = 0; k < ctbk_pkg::NUM_PRESCALE; k++)
        begin
            tick_info.strobe[k] = ((time_next & ctbk_pkg::prescale_mask(2'(k))) == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (tick_en)
        begin
            time_reg <= time_next;
        end
    end

endmodule

/* rtl/ctbk_cell.sv */
// One timer cell: counter, reload value and control byte, with carry to the next cell.
module ctbk_cell
#(
    parameter int COUNT_WIDTH = ctbk_pkg::COUNT_WIDTH_DEFAULT,
    parameter bit FIRST       = 1'b0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ctbk_pkg::ctbk_tick_t              tick_info,
    input  ctbk_pkg::ctbk_bus_t               bus,
    input  logic                              carry_in,
    output logic                              carry_out,
    output logic                              irq,
    output logic [COUNT_WIDTH-1:0]            count,
    output logic [ctbk_pkg::CTL_WIDTH-1:0]    control
);

    localparam int WW = (COUNT_WIDTH > ctbk_pkg::DATA_WIDTH) ? COUNT_WIDTH
                                                             : ctbk_pkg::DATA_WIDTH;

    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [COUNT_WIDTH-1:0]         count_next;
    logic [COUNT_WIDTH-1:0]         reload_reg;
    logic [COUNT_WIDTH-1:0]         reload_next;
    logic [ctbk_pkg::CTL_WIDTH-1:0] control_reg;
    logic [ctbk_pkg::CTL_WIDTH-1:0] control_next;
    logic [WW-1:0]                  reload_merge;
    logic                           inc;
    logic                           ovf;
    logic                           ctl_wr;
    logic                           rld_wr;

    assign ctl_wr = bus.wr_en && (bus.reg_sel == ctbk_pkg::REG_CONTROL) && bus.byte_enable[0];
    assign rld_wr = bus.wr_en && (bus.reg_sel == ctbk_pkg::REG_COUNT);

    always_comb
    begin
        if (!control_reg[ctbk_pkg::CTL_ENABLE_BIT])
        begin
            inc = 1'b0;
        end
        else if (!FIRST && control_reg[ctbk_pkg::CTL_COUNT_UP_BIT])
        begin
            inc = carry_in;
        end
        else
        begin
            inc = tick_info.strobe[control_reg[1:0]];
        end
        inc = inc && tick_info.tick;
        ovf = inc && (count_reg == '1);

        reload_merge = WW'(reload_reg);
        if (bus.byte_enable[0])
        begin
            reload_merge[7:0] = bus.write_data[7:0];
        end
        if (bus.byte_enable[1])
        begin
            reload_merge[15:8] = bus.write_data[15:8];
        end

        count_next   = count_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        if (inc)
        begin
            count_next = ovf ? reload_reg : count_reg + COUNT_WIDTH'(1);
        end
        if (rld_wr)
        begin
            reload_next = reload_merge[COUNT_WIDTH-1:0];
        end
        if (ctl_wr)
        begin
            control_next = bus.write_data[ctbk_pkg::CTL_WIDTH-1:0];
            // A rising enable restarts the counter from its reload value.
            if (!control_reg[ctbk_pkg::CTL_ENABLE_BIT]
                && bus.write_data[ctbk_pkg::CTL_ENABLE_BIT])
            begin
                count_next = reload_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            reload_reg  <= '0;
            control_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
        end
    end

    assign carry_out = ovf;
    assign irq       = ovf && control_reg[ctbk_pkg::CTL_IRQ_BIT];
    assign count     = count_reg;
    assign control   = control_reg;

endmodule

/* rtl/cascadable_timer_bank.sv */
// Top level of the cascadable timer bank: cell chain, prescaler and result buffer.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      op, timer_sel, reg_sel, byte_enable,
//                                                     write_data
//   result    out        result_valid / result_ready  read_data, irq_pulses
//
// One item is accepted per clock while item_ready is high; its result is registered in the
// output register, or in the skid register while the output is stalled.
// The overflow carry ripples combinationally through the cell chain.
// A second result register (skid) catches one beat while the output is stalled;
// item_ready drops only while that skid register is full.
// Reset clears all counters, reload values, control bytes and the prescale time.
module cascadable_timer_bank
#(
    parameter int NUM_TIMERS  = ctbk_pkg::NUM_TIMERS_DEFAULT,
    parameter int COUNT_WIDTH = ctbk_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        op,
    input  logic [1:0]                        timer_sel,
    input  logic                              reg_sel,
    input  logic [1:0]                        byte_enable,
    input  logic [ctbk_pkg::DATA_WIDTH-1:0]   write_data,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [ctbk_pkg::DATA_WIDTH-1:0]   read_data,
    output logic [ctbk_pkg::IRQ_WIDTH-1:0]    irq_pulses
);

    logic                             accept;
    logic                             is_tick;
    logic                             is_read;
    logic                             is_write;
    ctbk_pkg::ctbk_tick_t             tick_info;
    ctbk_pkg::ctbk_bus_t              bus   [NUM_TIMERS];
    logic [NUM_TIMERS:0]              carry;
    logic [NUM_TIMERS-1:0]            irq_vec;
    logic [COUNT_WIDTH-1:0]           count_vec   [NUM_TIMERS];
    logic [ctbk_pkg::CTL_WIDTH-1:0]   control_vec [NUM_TIMERS];
    logic [ctbk_pkg::DATA_WIDTH-1:0]  rd_value;
    logic [ctbk_pkg::IRQ_WIDTH-1:0]   irq_value;

    // Output register and skid register of the result channel.
    logic                             out_valid_reg;
    logic [ctbk_pkg::DATA_WIDTH-1:0]  out_data_reg;
    logic [ctbk_pkg::IRQ_WIDTH-1:0]   out_irq_reg;
    logic                             skid_valid_reg;
    logic [ctbk_pkg::DATA_WIDTH-1:0]  skid_data_reg;
    logic [ctbk_pkg::IRQ_WIDTH-1:0]   skid_irq_reg;
    logic                             out_free;

    assign item_ready = !skid_valid_reg;
    assign accept     = item_valid && item_ready;
    assign is_tick    = accept && (op == ctbk_pkg::OP_TICK);
    assign is_read    = (op == ctbk_pkg::OP_READ);
    assign is_write   = accept && (op == ctbk_pkg::OP_WRITE);

    ctbk_prescaler u_prescaler
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (is_tick),
        .tick_info (tick_info)
    );

    // Timer zero has no cascade input.
    assign carry[0] = 1'b0;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        always_comb
        begin
            bus[i].wr_en       = is_write && (int'(timer_sel) == i);
            bus[i].reg_sel     = reg_sel;
            bus[i].byte_enable = byte_enable;
            bus[i].write_data  = write_data;
        end

        ctbk_cell
        #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .FIRST       (i == 0)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .tick_info (tick_info),
            .bus       (bus[i]),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .irq       (irq_vec[i]),
            .count     (count_vec[i]),
            .control   (control_vec[i])
        );
    end

    // Read mux: a timer that does not exist reads as zero, and so does every non-read.
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (is_read && (int'(timer_sel) == i))
            begin
                if (reg_sel == ctbk_pkg::REG_CONTROL)
                begin
                    rd_value = ctbk_pkg::DATA_WIDTH'(control_vec[i]);
                end
                else
                begin
                    rd_value = ctbk_pkg::DATA_WIDTH'(count_vec[i]);
                end
            end
        end
        // Only the first four timers have an irq bit; the cells gate on tick already.
        irq_value = ctbk_pkg::IRQ_WIDTH'(irq_vec);
    end

    assign out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_irq_reg  <= skid_irq_reg;
            end
            else if (accept)
            begin
                out_data_reg <= rd_value;
                out_irq_reg  <= irq_value;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= rd_value;
            skid_irq_reg  <= irq_value;
        end
    end

    assign result_valid = out_valid_reg;
    assign read_data    = out_data_reg;
    assign irq_pulses   = out_irq_reg;

endmodule

/* rtl/ctbk_checker.sv */
// Port-level checker of the cascadable timer bank and its bind.
module ctbk_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [ctbk_pkg::DATA_WIDTH-1:0]  read_data,
    input logic [ctbk_pkg::IRQ_WIDTH-1:0]   irq_pulses
);

    // A stalled result beat holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready
        |=> result_valid && $stable(read_data) && $stable(irq_pulses))
        else $error("result beat changed while stalled");

    // Input back-pressure only appears while a result is waiting.
    a_ready_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("item_ready low with no result pending");

    // A beat accepted into a free output is shown on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (!result_valid || result_ready) |=> result_valid)
        else $error("accepted beat produced no result");

    // A beat accepted behind a stalled result fills the skid and drops ready.
    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && result_valid && !result_ready |=> !item_ready)
        else $error("beat accepted behind a stall did not block input");

endmodule

bind cascadable_timer_bank ctbk_checker u_ctbk_checker (.*);
